/* hw/rtl/assert_macros.svh */
// Assertion macros used by windowed_moving_average_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/wma_pkg.sv */
// Types and constants of the windowed moving average unit.
`timescale 1ns / 1ps
package wma_pkg;

  localparam int DEFAULT_MAX_WINDOW  = 256;
  localparam int DEFAULT_SAMPLE_BITS = 32;

  localparam int SUM_BITS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int DIV_BITS  = SUM_BITS + FRAC_BITS;
  localparam int STEP_BITS = $clog2(DIV_BITS + 1);

  localparam int ACTION_BITS    = 2;
  localparam int STATUS_BITS    = 2;
  localparam int WL_BITS        = 9;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 9;

  localparam logic [ACTION_BITS-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_NULL  = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_SAT      = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_MODE    = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SETUP,
    S_DIVIDE,
    S_FINISH,
    S_OUTPUT
  } state_t;

endpackage

/* hw/rtl/wma_if.sv */
// Valid/ready channel interfaces for input items and results.
`timescale 1ns / 1ps
interface wma_in_if
  import wma_pkg::*;
#(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic [ACTION_BITS-1:0]        action;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink (input valid, input action, input sample, output ready);
endinterface

interface wma_out_if
  import wma_pkg::*;
#(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] result;
  logic                          result_valid;
  logic [STATUS_BITS-1:0]        status;

  modport source (output valid, output result, output result_valid, output status,
                  input ready);
  modport sink (input valid, input result, input result_valid, input status,
                output ready);
endinterface

/* hw/rtl/windowed_moving_average_unit.sv */
// A result is shown after its item passes the update and setup states, the shared restoring
// divider (64 steps for an average, 80 for a ratio, one quotient bit per cycle) and the
// finish state; an invalid result or a zero-sum ratio goes from setup straight to output.
// Throughput: one item at a time; the next beat is taken once the result beat is taken.
// Reset (synchronous, rst high): pointer, count, sum and newest sample cleared,
// window_length = 1, ratio_mode = 0; the sample ring is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module windowed_moving_average_unit
  import wma_pkg::*;
#(
  parameter int MAX_WINDOW  = DEFAULT_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  wma_in_if.sink                    items,
  wma_out_if.source                 results
);

  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int PW = $clog2(MAX_WINDOW);
  localparam int CW = (NW > WL_BITS) ? NW : WL_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int MW = SB + NW;

  state_t state, state_next;

  logic [WL_BITS-1:0] window_length;
  logic               ratio_mode;

  logic [PW-1:0]                write_pointer;
  logic [NW-1:0]                sample_count;
  logic [SUM_BITS-1:0]          window_sum;
  logic signed [SB-1:0]         newest_sample;

  logic [SB-1:0]                sample_ring [MAX_WINDOW];
  logic [SB-1:0]                ring_rd;

  logic [ACTION_BITS-1:0]       action_q;
  logic signed [SB-1:0]         sample_q;

  logic                         neg;
  logic [SUM_BITS-1:0]          divisor;
  logic [DIV_BITS-1:0]          dividend;
  logic [SUM_BITS-1:0]          rem;
  logic [SB-1:0]                quo;
  logic                         quo_ovf;
  logic [STEP_BITS-1:0]         step;

  logic signed [SB-1:0]         res_q;
  logic                         res_valid_q;
  logic [STATUS_BITS-1:0]       status_q;

  logic                         accept;
  logic                         do_update;
  logic                         do_setup;
  logic                         do_divide;
  logic                         do_finish;

  logic [CW-1:0]                wl_ext;
  logic [NW-1:0]                n;
  logic [PW-1:0]                wp_eff;
  logic [PW-1:0]                wp_adv;
  logic [NW-1:0]                cnt_eff;
  logic                         full;
  logic signed [SB:0]           delta;
  logic [SUM_BITS-1:0]          delta_ext;

  logic                         win_ready;
  logic                         sum_zero;
  logic                         sum_neg;
  logic [SUM_BITS-1:0]          sum_mag;
  logic                         new_neg;
  logic [SB-1:0]                new_mag;
  logic [MW-1:0]                prod;

  logic [SUM_BITS:0]            rem_shift;
  logic                         rem_ge;
  logic [SB-1:0]                limit;
  logic                         sat;
  logic [SB-1:0]                quo_sel;

  // window length in effect
  always_comb begin
    wl_ext = CW'(window_length);
    if (wl_ext == '0) begin
      n = NW'(1);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      n = NW'(MAX_WINDOW);
    end else begin
      n = NW'(wl_ext);
    end
  end

  always_comb begin
    wp_eff    = (NW'(write_pointer) >= n) ? '0 : write_pointer;
    wp_adv    = ((NW'(wp_eff) + NW'(1)) >= n) ? '0 : PW'(wp_eff + PW'(1));
    cnt_eff   = (sample_count > n) ? n : sample_count;
    full      = (cnt_eff >= n);
    delta     = full ? ((SB+1)'(sample_q) - (SB+1)'($signed(ring_rd)))
                     : (SB+1)'(sample_q);
    delta_ext = {{(SUM_BITS-SB-1){delta[SB]}}, delta};
  end

  always_comb begin
    win_ready = (sample_count >= n);
    sum_zero  = (window_sum == '0);
    sum_neg   = window_sum[SUM_BITS-1];
    sum_mag   = sum_neg ? (~window_sum + SUM_BITS'(1)) : window_sum;
    new_neg   = newest_sample[SB-1];
    new_mag   = new_neg ? (~newest_sample + SB'(1)) : newest_sample;
    prod      = MW'(new_mag) * MW'(n);
  end

  always_comb begin
    rem_shift = {rem, dividend[DIV_BITS-1]};
    rem_ge    = (rem_shift >= {1'b0, divisor});
    limit     = neg ? (SB'(1) << (SB - 1)) : ((SB'(1) << (SB - 1)) - SB'(1));
    sat       = quo_ovf || (quo > limit);
    quo_sel   = sat ? limit : quo;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (items.valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_SETUP;
      end
      S_SETUP: begin
        if (!win_ready || (ratio_mode && sum_zero)) begin
          state_next = S_OUTPUT;
        end else begin
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (step == STEP_BITS'(1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_OUTPUT;
      end
      S_OUTPUT: begin
        if (results.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs and strobes
  always_comb begin
    items.ready   = 1'b0;
    results.valid = 1'b0;
    do_update     = 1'b0;
    do_setup      = 1'b0;
    do_divide     = 1'b0;
    do_finish     = 1'b0;
    case (state)
      S_IDLE:   items.ready   = !rst;
      S_UPDATE: do_update     = 1'b1;
      S_SETUP:  do_setup      = 1'b1;
      S_DIVIDE: do_divide     = 1'b1;
      S_FINISH: do_finish     = 1'b1;
      S_OUTPUT: results.valid = 1'b1;
      default: begin
        items.ready = 1'b0;
      end
    endcase
  end

  assign accept               = items.valid && items.ready;
  assign results.result       = res_q;
  assign results.result_valid = res_valid_q;
  assign results.status       = status_q;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WL_BITS'(1);
      ratio_mode    <= 1'b0;
      write_pointer <= '0;
      sample_count  <= '0;
      window_sum    <= '0;
      newest_sample <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: window_length <= cfg_data[WL_BITS-1:0];
          REG_RATIO_MODE:    ratio_mode    <= cfg_data[0];
          default: begin
            ratio_mode <= ratio_mode;
          end
        endcase
      end
      if (do_update) begin
        case (action_q)
          ACT_PUSH: begin
            write_pointer <= wp_adv;
            sample_count  <= full ? cnt_eff : NW'(cnt_eff + NW'(1));
            window_sum    <= window_sum + delta_ext;
            newest_sample <= sample_q;
          end
          ACT_CLEAR: begin
            write_pointer <= '0;
            sample_count  <= '0;
            window_sum    <= '0;
            newest_sample <= '0;
          end
          default: begin
            write_pointer <= wp_eff;
            sample_count  <= cnt_eff;
          end
        endcase
      end
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rd <= sample_ring[wp_eff];
    end
    if (do_update && (action_q == ACT_PUSH)) begin
      sample_ring[wp_eff] <= sample_q;
    end
  end

  // item beat, shared divider and result
  always_ff @(posedge clk) begin
    if (accept) begin
      action_q <= items.action;
      sample_q <= items.sample;
    end
    if (do_setup) begin
      rem     <= '0;
      quo     <= '0;
      quo_ovf <= 1'b0;
      if (ratio_mode) begin
        neg      <= new_neg ^ sum_neg;
        divisor  <= sum_mag;
        dividend <= {SUM_BITS'(prod), {FRAC_BITS{1'b0}}};
        step     <= STEP_BITS'(DIV_BITS);
      end else begin
        neg      <= sum_neg;
        divisor  <= SUM_BITS'(n);
        dividend <= {sum_mag, {FRAC_BITS{1'b0}}};
        step     <= STEP_BITS'(SUM_BITS);
      end
      res_q       <= '0;
      res_valid_q <= win_ready;
      status_q    <= (win_ready && ratio_mode && sum_zero) ? ST_DIV_ZERO : ST_OK;
    end
    if (do_divide) begin
      rem      <= rem_ge ? SUM_BITS'(rem_shift - {1'b0, divisor}) : rem_shift[SUM_BITS-1:0];
      dividend <= {dividend[DIV_BITS-2:0], 1'b0};
      quo      <= {quo[SB-2:0], rem_ge};
      quo_ovf  <= quo_ovf | quo[SB-1];
      step     <= step - STEP_BITS'(1);
    end
    if (do_finish) begin
      res_q       <= neg ? (~quo_sel + SB'(1)) : quo_sel;
      res_valid_q <= 1'b1;
      status_q    <= sat ? ST_SAT : ST_OK;
    end
  end

  `ASSERT_HOLDS(a_one_side, clk, rst, !(items.ready && results.valid),
                "ready while result held")
  `ASSERT_HOLDS(a_invalid_zero, clk, rst,
                !(results.valid && !results.result_valid) ||
                ((results.result == '0) && (results.status == ST_OK)),
                "invalid result not zero")
  `ASSERT_HOLDS(a_status_valid, clk, rst,
                !(results.valid && (results.status != ST_OK)) || results.result_valid,
                "status without valid result")
  `ASSERT_NEXT(a_accept_update, clk, rst, accept, (state == S_UPDATE),
               "beat not processed")

endmodule
